FILE: design/hehd_pkg.sv
// Package: item types, decision codes and register indexes for the height decider
`timescale 1ns / 1ps

package hehd_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   // register indexes on the write port
   localparam logic [CSR_INDEX_W-1:0] CSR_ENABLE         = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DOUBLE_SUPPORT = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_STEP       = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_BAND           = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_PERIOD     = 3'd4;

   // item kinds
   localparam logic KIND_HEIGHT = 1'b0;
   localparam logic KIND_FORCE  = 1'b1;

   // decision codes
   localparam logic [1:0] DEC_NONE    = 2'd0;
   localparam logic [1:0] DEC_STEP_UP = 2'd1;
   localparam logic [1:0] DEC_AVOID   = 2'd2;
   localparam logic [1:0] DEC_INVALID = 2'd3;

   localparam logic [1:0] FEET_BOTH = 2'd2;

   // EMA: new gain 0.3 in Q0.16; the old gain is 1 - 0.3
   localparam logic [15:0] EMA_GAIN  = 16'd19661;
   localparam logic [32:0] EMA_ROUND = 33'd32768;

   // register reset values
   localparam logic        RST_ENABLE         = 1'b1;
   localparam logic        RST_DOUBLE_SUPPORT = 1'b0;
   localparam logic [15:0] RST_MAX_STEP       = 16'd410;
   localparam logic [13:0] RST_BAND           = 14'd82;
   localparam logic [31:0] RST_MIN_PERIOD     = 32'd0;

   typedef struct packed {
      logic               kind;
      logic signed [15:0] height_sample;
      logic [31:0]        now_ticks;
      logic [1:0]         feet_in_contact;
      logic [31:0]        sample_stamp;
      logic [1:0]         forced_decision;
   } req_item_type;

   typedef struct packed {
      logic               accepted;
      logic signed [15:0] filtered_height;
      logic [1:0]         decision;
      logic               filter_valid;
      logic [15:0]        stable_count;
      logic [31:0]        last_stamp;
   } rsp_item_type;

endpackage

FILE: design/height_ema_hysteresis_decider.sv
// Top level: obstacle height EMA filter with hysteresis step-up / avoid decision
// Path from req accept to rsp valid: input register, then result register; the filter
// update (one 17x16 multiply, add, band compare) sits between the two.
// Throughput: one item per cycle unless the result stage stalls on rsp_ready.
// req_ready is high whenever the input register is empty or drains in the same cycle.
// Reset (synchronous): registers to their defaults, filter, count, decision and stamps
// cleared, both stages empty.
`timescale 1ns / 1ps

module height_ema_hysteresis_decider
   import hehd_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_item_type           req_item,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_item_type           rsp_item,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   // configuration registers
   logic        enable_ff;
   logic        double_support_ff;
   logic [15:0] max_step_ff;
   logic [13:0] band_ff;
   logic [31:0] min_period_ff;

   // input stage
   logic         in_valid_ff;
   req_item_type in_item_ff;

   // filter and decision state
   logic signed [15:0] filt_ff,  filt_in;
   logic               fvalid_ff, fvalid_in;
   logic [15:0]        count_ff, count_in;
   logic [1:0]         dec_ff,   dec_in;
   logic [31:0]        last_time_ff, last_time_in;
   logic               has_acc_ff, has_acc_in;
   logic [31:0]        stamp_ff, stamp_in;

   // result stage
   logic         rsp_valid_ff;
   rsp_item_type rsp_item_ff, rsp_item_in;

   logic advance;

   logic signed [16:0] ema_diff;
   logic signed [32:0] ema_prod;
   logic signed [32:0] ema_round;
   logic signed [16:0] ema_delta;
   logic signed [16:0] ema_sum;
   logic signed [15:0] filt_new;
   logic signed [17:0] band_hi;
   logic signed [17:0] band_lo;
   logic [31:0]        elapsed;
   logic               take;
   logic               acc;

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // filt' = filt + floor((0.3 * (h - filt) + 0.5)) in Q0.16
   assign ema_diff  = $signed({in_item_ff.height_sample[15], in_item_ff.height_sample})
                    - $signed({filt_ff[15], filt_ff});
   assign ema_prod  = $signed({{16{ema_diff[16]}}, ema_diff}) * $signed({17'b0, EMA_GAIN});
   assign ema_round = ema_prod + $signed(EMA_ROUND);
   assign ema_delta = ema_round[32:16];
   assign ema_sum   = $signed({filt_ff[15], filt_ff}) + ema_delta;

   assign band_hi = $signed({{2{max_step_ff[15]}}, max_step_ff}) + $signed({4'b0, band_ff});
   assign band_lo = $signed({{2{max_step_ff[15]}}, max_step_ff}) - $signed({4'b0, band_ff});

   assign elapsed = in_item_ff.now_ticks - last_time_ff;

   always_comb begin
      filt_in      = filt_ff;
      fvalid_in    = fvalid_ff;
      count_in     = count_ff;
      dec_in       = dec_ff;
      last_time_in = last_time_ff;
      has_acc_in   = has_acc_ff;
      stamp_in     = stamp_ff;
      acc          = 1'b0;
      filt_new     = fvalid_ff ? ema_sum[15:0] : in_item_ff.height_sample;

      take = enable_ff;
      if (double_support_ff && (in_item_ff.feet_in_contact != FEET_BOTH)) begin
         take = 1'b0;
      end
      if (has_acc_ff && (elapsed < min_period_ff)) begin
         take = 1'b0;
      end

      if (in_item_ff.kind == KIND_FORCE) begin
         // undefined force code is ignored
         if (in_item_ff.forced_decision != DEC_INVALID) begin
            dec_in = in_item_ff.forced_decision;
            acc    = 1'b1;
         end
      end else if (take) begin
         filt_in   = filt_new;
         fvalid_in = 1'b1;
         if (!fvalid_ff) begin
            count_in = 16'd1;
         end else if (count_ff != 16'hFFFF) begin
            count_in = count_ff + 16'd1;
         end
         if ($signed({{2{filt_new[15]}}, filt_new}) > band_hi) begin
            dec_in = DEC_AVOID;
         end else if ($signed({{2{filt_new[15]}}, filt_new}) < band_lo) begin
            dec_in = DEC_STEP_UP;
         end
         stamp_in     = in_item_ff.sample_stamp;
         last_time_in = in_item_ff.now_ticks;
         has_acc_in   = 1'b1;
         acc          = 1'b1;
      end

      rsp_item_in.accepted        = acc;
      rsp_item_in.filtered_height = filt_in;
      rsp_item_in.decision        = dec_in;
      rsp_item_in.filter_valid    = fvalid_in;
      rsp_item_in.stable_count    = count_in;
      rsp_item_in.last_stamp      = stamp_in;
   end

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff         <= RST_ENABLE;
         double_support_ff <= RST_DOUBLE_SUPPORT;
         max_step_ff       <= RST_MAX_STEP;
         band_ff           <= RST_BAND;
         min_period_ff     <= RST_MIN_PERIOD;
      end else if (csr_we) begin
         case (csr_index)
            CSR_ENABLE:         enable_ff         <= csr_wdata[0];
            CSR_DOUBLE_SUPPORT: double_support_ff <= csr_wdata[0];
            CSR_MAX_STEP:       max_step_ff       <= csr_wdata[15:0];
            CSR_BAND:           band_ff           <= csr_wdata[13:0];
            CSR_MIN_PERIOD:     min_period_ff     <= csr_wdata[31:0];
            default: ;
         endcase
      end
   end

   // input stage
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_item_ff <= req_item;
      end
   end

   // filter state and result stage
   always_ff @(posedge clock) begin
      if (reset) begin
         filt_ff      <= '0;
         fvalid_ff    <= 1'b0;
         count_ff     <= '0;
         dec_ff       <= DEC_NONE;
         last_time_ff <= '0;
         has_acc_ff   <= 1'b0;
         stamp_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            filt_ff      <= filt_in;
            fvalid_ff    <= fvalid_in;
            count_ff     <= count_in;
            dec_ff       <= dec_in;
            last_time_ff <= last_time_in;
            has_acc_ff   <= has_acc_in;
            stamp_ff     <= stamp_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

endmodule
